>>> sv/fpmsd_pkg.sv
package fpmsd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ORDER_W  = 8;
    localparam int BSIZE_W  = 16;
    localparam int TOTAL_W  = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [ORDER_W-1:0]         t_order;
    typedef logic [BSIZE_W-1:0]         t_bsize;
    typedef logic [TOTAL_W-1:0]         t_total;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;

    localparam t_cfg_idx CFG_ORDER = 2'd0;
    localparam t_cfg_idx CFG_BSIZE = 2'd1;
    localparam t_cfg_idx CFG_TOTAL = 2'd2;

    localparam t_order ORD_ZERO  = 8'd0;
    localparam t_order ORD_LIN   = 8'd2;
    localparam t_order ORD_QUAD  = 8'd3;

    localparam t_order RST_ORDER = 8'd2;
    localparam t_bsize RST_BSIZE = 16'd4096;
    localparam t_total RST_TOTAL = 32'hFFFF_FFFF;

    typedef struct packed {
        logic live;
        logic warm;
        logic blast;
        logic slast;
    } t_ctrl;

endpackage

>>> sv/fpmsd_predictor.sv
module fpmsd_predictor (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fpmsd_pkg::t_sample i_code,
    input  logic              i_warm,
    input  fpmsd_pkg::t_order  i_order,
    input  logic              i_update,
    output fpmsd_pkg::t_sample o_sample
);
    import fpmsd_pkg::*;

    logic [SAMPLE_W-1:0] r_hist_a, r_hist_b, r_hist_c;
    logic [SAMPLE_W-1:0] pred;
    logic [SAMPLE_W-1:0] sample;

    always_comb begin
        case (i_order)
            ORD_ZERO: pred = '0;
            ORD_LIN:  pred = (r_hist_a << 1) - r_hist_b;
            ORD_QUAD: pred = (r_hist_a << 1) + r_hist_a - (r_hist_b << 1) - r_hist_b + r_hist_c;
            default:  pred = r_hist_a;
        endcase
    end

    assign sample   = i_warm ? i_code : pred + i_code;
    assign o_sample = sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_a <= '0;
            r_hist_b <= '0;
            r_hist_c <= '0;
        end else if (i_update) begin
            r_hist_c <= r_hist_b;
            r_hist_b <= r_hist_a;
            r_hist_a <= sample;
        end
    end

endmodule

>>> sv/fpmsd_control.sv
module fpmsd_control (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  fpmsd_pkg::t_cfg_idx  i_cfg_index,
    input  logic [fpmsd_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                i_advance,
    output fpmsd_pkg::t_order    o_order,
    output fpmsd_pkg::t_ctrl     o_ctrl
);
    import fpmsd_pkg::*;

    t_order r_order;
    t_bsize r_bsize;
    t_bsize r_frame;
    t_total r_left;

    logic [ORDER_W-1:0] warm_len;
    logic [BSIZE_W:0]   frame_inc;
    logic [BSIZE_W:0]   bsize_eff;
    logic               live;
    logic               slast;
    logic               blast;

    assign warm_len  = (r_order == ORD_ZERO) ? ORDER_W'(1) : r_order;
    assign frame_inc = {1'b0, r_frame} + (BSIZE_W+1)'(1);
    assign bsize_eff = {(r_bsize == '0), r_bsize};
    assign live      = (r_left != '0);
    assign slast     = (r_left == TOTAL_W'(1));
    assign blast     = slast || (frame_inc >= bsize_eff);

    assign o_order      = r_order;
    assign o_ctrl.live  = live;
    assign o_ctrl.warm  = ({1'b0, r_frame} < (BSIZE_W+1)'(warm_len));
    assign o_ctrl.blast = blast;
    assign o_ctrl.slast = slast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= RST_ORDER;
            r_bsize <= RST_BSIZE;
            r_frame <= '0;
            r_left  <= RST_TOTAL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ORDER: r_order <= i_cfg_data[ORDER_W-1:0];
                CFG_BSIZE: r_bsize <= i_cfg_data[BSIZE_W-1:0];
                CFG_TOTAL: begin
                    r_left  <= i_cfg_data[TOTAL_W-1:0];
                    r_frame <= '0;
                end
                default: ;
            endcase
        end else if (i_advance && live) begin
            r_left  <= r_left - TOTAL_W'(1);
            r_frame <= blast ? '0 : frame_inc[BSIZE_W-1:0];
        end
    end

endmodule

>>> sv/fixed_predictor_mid_side_decoder_unit.sv
// An accepted item is held in the input register until the result register is free, then registered there.
// Throughput: one item per cycle unless the output stalls; history update and mid/side math fit between registers.
// Items that arrive after the stream has ended are taken and dropped without a result.
// Reset (synchronous, active low) restores order 2, block size 4096, 4294967295 frames,
// clears the sample history and the frame count, and empties both registers.
module fixed_predictor_mid_side_decoder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  fpmsd_pkg::t_sample             i_mid_code,
    input  fpmsd_pkg::t_sample             i_side_code,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output fpmsd_pkg::t_sample             o_left_sample,
    output fpmsd_pkg::t_sample             o_right_sample,
    output logic                          o_block_last,
    output logic                          o_stream_last,
    input  logic                          i_cfg_we,
    input  fpmsd_pkg::t_cfg_idx            i_cfg_index,
    input  logic [fpmsd_pkg::CFG_W-1:0]    i_cfg_data
);
    import fpmsd_pkg::*;

    logic    r_in_valid;
    t_sample r_mid_code, r_side_code;
    logic    r_out_valid;
    t_sample r_left, r_right;
    logic    r_blast, r_slast;

    t_order  order;
    t_ctrl   ctrl;
    logic    advance;
    logic    load;
    t_sample mid, side;
    logic signed [SAMPLE_W:0] side_ext;
    logic signed [SAMPLE_W:0] side_up;
    logic signed [SAMPLE_W:0] side_dn;
    logic signed [SAMPLE_W:0] mid_ext;
    logic signed [SAMPLE_W:0] left_sum;
    logic signed [SAMPLE_W:0] right_sum;

    assign advance    = r_in_valid && (!ctrl.live || !r_out_valid || i_out_ready);
    assign load       = advance && ctrl.live;
    assign o_in_ready = !r_in_valid || advance;

    fpmsd_control u_control (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (advance),
        .o_order     (order),
        .o_ctrl      (ctrl)
    );

    fpmsd_predictor u_mid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_code   (r_mid_code),
        .i_warm   (ctrl.warm),
        .i_order  (order),
        .i_update (load),
        .o_sample (mid)
    );

    fpmsd_predictor u_side (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_code   (r_side_code),
        .i_warm   (ctrl.warm),
        .i_order  (order),
        .i_update (load),
        .o_sample (side)
    );

    assign side_ext  = {side[SAMPLE_W-1], side};
    assign mid_ext   = {mid[SAMPLE_W-1], mid};
    assign side_up   = (side_ext + (SAMPLE_W+1)'(1)) >>> 1;
    assign side_dn   = side_ext >>> 1;
    assign left_sum  = mid_ext + side_up;
    assign right_sum = mid_ext - side_dn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_mid_code  <= i_mid_code;
            r_side_code <= i_side_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_left  <= left_sum[SAMPLE_W-1:0];
            r_right <= right_sum[SAMPLE_W-1:0];
            r_blast <= ctrl.blast;
            r_slast <= ctrl.slast;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_left_sample  = r_left;
    assign o_right_sample = r_right;
    assign o_block_last   = r_blast;
    assign o_stream_last  = r_slast;

    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while holding an item");

    a_stream_ends_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_slast) |-> r_blast)
        else $error("stream end without block end");

    a_stall_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && ctrl.live && r_out_valid && !i_out_ready))
        else $error("input stalled without a blocked item");

    a_after_stream_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && ctrl.slast && !i_cfg_we) |=> !ctrl.live)
        else $error("frames remain after the final item");

endmodule
